FILE: rtl/core/cof_pkg.sv
// Shared types and constants for the circle overlap first-match block.
package cof_pkg;

  // Request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_WR_ENTRY  = 2'd0,
    REQ_WR_PLAYER = 2'd1,
    REQ_QRY_PLAYER = 2'd2,
    REQ_QRY_ENTRY = 2'd3
  } req_e;

  // Register index of active_count (byte address bit 2 selects the register)
  localparam logic REG_ACTIVE_COUNT = 1'b0;

  // One stored circle
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        r;
    logic               moving;
  } circ_t;

  localparam int CIRC_W = $bits(circ_t);

  // One result item
  typedef struct packed {
    logic       hit;
    logic [5:0] partner;
    logic       is_player;
  } res_t;

endpackage

FILE: rtl/core/cof_ram.sv
// Generic simple dual-port RAM with registered read data.
module cof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/cof_overlap.sv
// Two-stage pipelined circle overlap test: squares, then sum and compare.
module cof_overlap #(
  parameter int TAG_W = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  cof_pkg::circ_t      a_i,
  input  cof_pkg::circ_t      b_i,
  output logic                busy_o,
  output logic                valid_o,
  output logic [TAG_W-1:0]    tag_o,
  output logic                overlap_o
);

  logic signed [16:0] dx, dy;
  logic signed [33:0] dxx, dyy;
  logic [12:0]        rs;
  logic [25:0]        rss;

  logic               s1_v_q;
  logic [TAG_W-1:0]   s1_tag_q;
  logic [31:0]        dxx_q, dyy_q;
  logic [25:0]        rss_q;
  logic [32:0]        d2;

  // Differences and squares
  assign dx  = {a_i.x[15], a_i.x} - {b_i.x[15], b_i.x};
  assign dy  = {a_i.y[15], a_i.y} - {b_i.y[15], b_i.y};
  assign dxx = dx * dx;
  assign dyy = dy * dy;
  assign rs  = 13'({1'b0, a_i.r} + {1'b0, b_i.r} + 13'd1);
  assign rss = rs * rs;

  // Squared distance against the square of the radius sum plus one
  assign d2 = {1'b0, dxx_q} + {1'b0, dyy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      s1_v_q  <= valid_i;
      valid_o <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q  <= tag_i;
    dxx_q     <= dxx[31:0];
    dyy_q     <= dyy[31:0];
    rss_q     <= rss;
    tag_o     <= s1_tag_q;
    overlap_o <= d2 < {7'd0, rss_q};
  end

  assign busy_o = s1_v_q;

endmodule

FILE: rtl/core/circle_overlap_first_match.sv
// Circle table with first-match overlap queries, one request at a time.
// Writes also return a result. A query tests at most lim entries, where
// lim = min(active_count, MAX_ENTRIES); an entry hit ends the scan early.
// Rate is set by the single table read port: one entry tested per cycle; the next request
// is taken the cycle after its result is loaded, which waits while the output is stalled.
// After reset a clearing pass zeroes every table entry, with in_ready low.
module circle_overlap_first_match #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [11:0]        circle_radius_i,
  input  logic               is_moving_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [5:0]         partner_index_o,
  output logic               partner_is_player_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [6:0]             acnt_q;
  cof_pkg::circ_t         player_q, player_d;
  cof_pkg::circ_t         ref_q, ref_d;
  logic                   mode_ent_q, mode_ent_d;
  logic [LW-1:0]          idx_q, idx_d;
  logic [LW-1:0]          issue_q, issue_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [AW-1:0]          rd_tag_q, rd_tag_d;
  logic                   ph_q, ph_d;
  cof_pkg::res_t          res_q, res_d;
  logic                   out_v_q, out_v_d;
  cof_pkg::res_t          out_q, out_d;

  logic [LW-1:0]          lim, idx_in;
  logic                   idx_ok;
  logic                   cfg_wr;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  cof_pkg::circ_t         ram_wdata, ram_rdata;

  logic                   u_in_v, u_busy, u_out_v, u_out_ov;
  logic [AW:0]            u_tag, u_out_tag;
  cof_pkg::circ_t         u_a, u_b;

  logic                   pl_now, ent_hit, all_done;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == cof_pkg::REG_ACTIVE_COUNT) ? {25'd0, acnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acnt_q <= 7'd0;
    end else if (cfg_wr && paddr[2] == cof_pkg::REG_ACTIVE_COUNT) begin
      acnt_q <= pwdata[6:0];
    end
  end

  // Scan limit and index range
  assign lim    = (LW'(acnt_q) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(acnt_q);
  assign idx_in = LW'(entry_index_i);
  assign idx_ok = idx_in < LW'(MAX_ENTRIES);

  // Table memory
  cof_ram #(
    .WIDTH (cof_pkg::CIRC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Overlap unit; tag top bit marks the player test
  cof_overlap #(
    .TAG_W (AW + 1)
  ) u_ovl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (u_in_v),
    .tag_i     (u_tag),
    .a_i       (u_a),
    .b_i       (u_b),
    .busy_o    (u_busy),
    .valid_o   (u_out_v),
    .tag_o     (u_out_tag),
    .overlap_o (u_out_ov)
  );

  assign pl_now   = u_out_v && u_out_tag[AW] && u_out_ov;
  assign ent_hit  = u_out_v && !u_out_tag[AW] && u_out_ov;
  assign all_done = (issue_q >= lim) && !rd_pend_q && !u_busy;

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    player_d   = player_q;
    ref_d      = ref_q;
    mode_ent_d = mode_ent_q;
    idx_d      = idx_q;
    issue_d    = issue_q;
    rd_pend_d  = 1'b0;
    rd_tag_d   = rd_tag_q;
    ph_d       = ph_q;
    res_d      = res_q;
    out_v_d    = out_v_q & ~out_ready_i;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_wdata  = '0;
    ram_raddr  = issue_q[AW-1:0];
    u_in_v     = 1'b0;
    u_tag      = {1'b0, rd_tag_q};
    u_a        = mode_ent_q ? ref_q : player_q;
    u_b        = ram_rdata;

    case (state_q)
      ST_CLEAR: begin
        // Zero one entry a cycle
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(MAX_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          issue_d = '0;
          ph_d    = 1'b0;
          idx_d   = idx_in;
          state_d = ST_RESP;
          case (cof_pkg::req_e'(req_type_i))
            cof_pkg::REQ_WR_ENTRY: begin
              ram_we    = idx_ok;
              ram_waddr = idx_in[AW-1:0];
              ram_wdata = {pos_x_i, pos_y_i, circle_radius_i, is_moving_i};
            end
            cof_pkg::REQ_WR_PLAYER: begin
              player_d = {pos_x_i, pos_y_i, circle_radius_i, is_moving_i};
            end
            cof_pkg::REQ_QRY_PLAYER: begin
              mode_ent_d = 1'b0;
              if (player_q.moving) begin
                state_d = ST_SCAN;
              end
            end
            cof_pkg::REQ_QRY_ENTRY: begin
              mode_ent_d = 1'b1;
              ram_raddr  = idx_in[AW-1:0];
              if (idx_ok) begin
                state_d = ST_FETCH;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_FETCH: begin
        // Queried entry arrives; a moving one is tested against the player first
        if (!ram_rdata.moving) begin
          state_d = ST_RESP;
        end else begin
          ref_d   = ram_rdata;
          u_in_v  = 1'b1;
          u_tag   = {1'b1, AW'(0)};
          u_a     = player_q;
          u_b     = ram_rdata;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle, skip the queried entry itself
        if (issue_q < lim) begin
          rd_pend_d = !(mode_ent_q && issue_q == idx_q);
          rd_tag_d  = issue_q[AW-1:0];
          issue_d   = issue_q + 1'b1;
        end
        u_in_v = rd_pend_q;
        ph_d   = ph_q | pl_now;
        // Stop on the first entry overlap or once everything has drained
        if (ent_hit || all_done) begin
          state_d = ST_RESP;
          if (mode_ent_q && (ph_q || pl_now)) begin
            res_d = '{hit: 1'b1, partner: 6'd0, is_player: 1'b1};
          end else if (ent_hit) begin
            res_d = '{hit: 1'b1, partner: 6'(u_out_tag[AW-1:0]), is_player: 1'b0};
          end else begin
            res_d = '0;
          end
        end
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          out_d   = res_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      player_q  <= '0;
      rd_pend_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      player_q  <= player_d;
      rd_pend_q <= rd_pend_d;
      out_v_q   <= out_v_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    ref_q      <= ref_d;
    mode_ent_q <= mode_ent_d;
    idx_q      <= idx_d;
    issue_q    <= issue_d;
    rd_tag_q   <= rd_tag_d;
    ph_q       <= ph_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o         = out_v_q;
  assign hit_o               = out_q.hit;
  assign partner_index_o     = out_q.partner;
  assign partner_is_player_o = out_q.is_player;

endmodule

FILE: rtl/core/cof_checker.sv
// Port-level checks for the circle overlap first-match block, bound to the top level.
module cof_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       hit_o,
  input logic [5:0] partner_index_o,
  input logic       partner_is_player_o
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o)
      && $stable(partner_index_o) && $stable(partner_is_player_o))
    else $error("stalled result changed or dropped");

  // Take one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one still in work");

  // A player match names no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && partner_is_player_o |-> hit_o && partner_index_o == 6'd0)
    else $error("player match with entry index or without hit");

  // No hit means an empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> partner_index_o == 6'd0 && !partner_is_player_o)
    else $error("miss result carries a partner");

endmodule

bind circle_overlap_first_match cof_checker u_cof_checker (.*);

FILE: verif/circle_overlap_first_match_test.sv
// Self-checking testbench for the circle overlap first-match block.
module circle_overlap_first_match_test;

  localparam int          MAX_ENTRIES       = 64;
  localparam int          CYCLE_LIMIT       = 1_000_000;
  localparam int          ITEMS_PER_PHASE   = 210;
  localparam int          PRINT_CAP         = 40;
  localparam logic [2:0]  ADDR_ACTIVE_COUNT = {cof_pkg::REG_ACTIVE_COUNT, 2'b00};

  // Expected-result tracker: a copy of the circle table and the player
  class circle_table_model;
    cof_pkg::circ_t entries[MAX_ENTRIES];
    cof_pkg::circ_t player;
    int unsigned    active_count;
    cof_pkg::res_t  pending_results[$];
    int unsigned    mismatch_count;

    function new();
      foreach (entries[k]) entries[k] = '0;
      player         = '0;
      active_count   = 0;
      mismatch_count = 0;
    endfunction

    // Integer form of "floor of centre distance <= radius sum"
    static function bit circles_overlap(cof_pkg::circ_t a, cof_pkg::circ_t b);
      longint dx;
      longint dy;
      longint reach;
      dx    = longint'($signed(a.x)) - longint'($signed(b.x));
      dy    = longint'($signed(a.y)) - longint'($signed(b.y));
      reach = longint'(a.r) + longint'(b.r) + 1;
      return (dx * dx + dy * dy) < (reach * reach);
    endfunction

    // Apply one accepted transfer and queue the result it must produce
    function void note_request(cof_pkg::req_e kind, logic [5:0] idx, cof_pkg::circ_t c);
      cof_pkg::res_t  res;
      int unsigned    lim;
      cof_pkg::circ_t probe;
      res = '0;
      lim = (active_count > MAX_ENTRIES) ? MAX_ENTRIES : active_count;
      case (kind)
        cof_pkg::REQ_WR_ENTRY: begin
          if (idx < MAX_ENTRIES) entries[idx] = c;
        end
        cof_pkg::REQ_WR_PLAYER: begin
          player = c;
        end
        cof_pkg::REQ_QRY_PLAYER: begin
          if (player.moving) begin
            for (int k = 0; k < lim; k++) begin
              if (circles_overlap(player, entries[k])) begin
                res.hit     = 1'b1;
                res.partner = 6'(k);
                break;
              end
            end
          end
        end
        default: begin
          if (idx < MAX_ENTRIES && entries[idx].moving) begin
            probe = entries[idx];
            for (int k = 0; k < lim; k++) begin
              if (k != idx && circles_overlap(probe, entries[k])) begin
                res.hit     = 1'b1;
                res.partner = 6'(k);
                break;
              end
            end
            // player overlap overrides any entry match
            if (circles_overlap(player, probe)) begin
              res.hit       = 1'b1;
              res.partner   = '0;
              res.is_player = 1'b1;
            end
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("MISMATCH: %s", what);
    endtask

    // Compare one accepted result against the oldest expectation
    task check_result(logic hit, logic [5:0] partner, logic is_player);
      cof_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no expectation pending");
        return;
      end
      want = pending_results.pop_front();
      if (hit !== want.hit)
        report_mismatch($sformatf("hit got %b want %b", hit, want.hit));
      if (partner !== want.partner)
        report_mismatch($sformatf("partner_index got %0d want %0d", partner, want.partner));
      if (is_player !== want.is_player)
        report_mismatch($sformatf("partner_is_player got %b want %b",
                                  is_player, want.is_player));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic [5:0]         entry_index_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic [11:0]        circle_radius_i;
  logic               is_moving_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               hit_o;
  logic [5:0]         partner_index_o;
  logic               partner_is_player_o;

  circle_table_model circle_table;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       scan_count;
  int unsigned       cycle_count;

  circle_overlap_first_match #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .entry_index_i      (entry_index_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .circle_radius_i    (circle_radius_i),
    .is_moving_i        (is_moving_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hit_o              (hit_o),
    .partner_index_o    (partner_index_o),
    .partner_is_player_o(partner_is_player_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check completed transfers on the result side, then choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      circle_table.check_result(hit_o, partner_index_o, partner_is_player_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic cof_pkg::circ_t make_circle(int x, int y, int r, bit mv);
    cof_pkg::circ_t c;
    c.x      = 16'(x);
    c.y      = 16'(y);
    c.r      = 12'(r);
    c.moving = mv;
    return c;
  endfunction

  task automatic write_active_count(logic [6:0] count);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_COUNT;
    pwdata  <= 32'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    circle_table.active_count = count;
    scan_count                = count;
  endtask

  // Present one request and hold it until the transfer completes
  task automatic send_request(cof_pkg::req_e kind, logic [5:0] idx, cof_pkg::circ_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    entry_index_i   <= idx;
    pos_x_i         <= c.x;
    pos_y_i         <= c.y;
    circle_radius_i <= c.r;
    is_moving_i     <= c.moving;
    do @(posedge clk_i); while (!in_ready_o);
    circle_table.note_request(kind, idx, c);
  endtask

  task automatic wait_drained();
    while (circle_table.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random request: mostly clustered circles so that overlaps are common
  task automatic send_random_request();
    cof_pkg::req_e  kind;
    logic [5:0]     idx;
    cof_pkg::circ_t c;
    int unsigned    roll;
    int unsigned    lim;
    roll = $urandom_range(99);
    if (roll < 40)      kind = cof_pkg::REQ_WR_ENTRY;
    else if (roll < 50) kind = cof_pkg::REQ_WR_PLAYER;
    else if (roll < 72) kind = cof_pkg::REQ_QRY_PLAYER;
    else                kind = cof_pkg::REQ_QRY_ENTRY;
    lim = (scan_count > MAX_ENTRIES) ? MAX_ENTRIES : scan_count;
    if (lim > 0 && $urandom_range(99) < 85) idx = 6'($urandom_range(lim - 1));
    else                                    idx = 6'($urandom);
    if ($urandom_range(99) < 85) begin
      c.x = 16'($urandom_range(1200) - 600);
      c.y = 16'($urandom_range(1200) - 600);
    end else begin
      c.x = 16'($urandom);
      c.y = 16'($urandom);
    end
    c.r      = ($urandom_range(99) < 80) ? 12'($urandom_range(300)) : 12'($urandom);
    c.moving = ($urandom_range(99) < 80);
    send_request(kind, idx, c);
  endtask

  // Main sequence
  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    int unsigned count_plan[4];
    circle_table    = new();
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    req_type_i      = cof_pkg::REQ_WR_ENTRY;
    entry_index_i   = '0;
    pos_x_i         = '0;
    pos_y_i         = '0;
    circle_radius_i = '0;
    is_moving_i     = 1'b0;
    out_ready_i     = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    scan_count      = 0;
    cycle_count     = 0;
    idle_plan       = '{0, 65, 0, 16};
    stall_plan      = '{0, 0, 65, 16};
    count_plan      = '{64, $urandom_range(2, 63), 127, $urandom_range(64)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: gating before anything moves, then boundary geometry
    write_active_count(7'd4);
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_WR_PLAYER, 6'd0, make_circle(32767, -32768, 0, 0));
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd0, make_circle(0, 0, 10, 1));
    // just touching: distance equals the radius sum
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd1, make_circle(20, 0, 10, 0));
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd2, make_circle(-32768, -32768, 4095, 1));
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd3, make_circle(32767, 32767, 4095, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd0, make_circle(0, 0, 0, 1));
    // one unit apart
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd1, make_circle(21, 0, 10, 0));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd2, make_circle(0, 0, 0, 1));
    // moving query with the player still parked
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd63, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_WR_PLAYER, 6'd63, make_circle(5, 5, 4095, 1));
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd0, make_circle(0, 0, 0, 0));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd0, make_circle(-1, -1, 4095, 0));
    // queried entry beyond the active range
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd5, make_circle(0, 0, 100, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd5, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd3, make_circle(0, 0, 0, 0));
    send_request(cof_pkg::REQ_WR_PLAYER, 6'd0, make_circle(32767, 32767, 0, 1));
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_WR_ENTRY, 6'd63, make_circle(32767, 32767, 4095, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd63, make_circle(0, 0, 0, 1));
    in_valid_i <= 1'b0;
    wait_drained();
    // count above the table size clamps
    write_active_count(7'd127);
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd63, make_circle(0, 0, 0, 1));
    in_valid_i <= 1'b0;
    wait_drained();
    // empty scan: only the player test is left
    write_active_count(7'd0);
    send_request(cof_pkg::REQ_QRY_PLAYER, 6'd0, make_circle(0, 0, 0, 1));
    send_request(cof_pkg::REQ_QRY_ENTRY, 6'd3, make_circle(0, 0, 0, 1));
    in_valid_i <= 1'b0;
    wait_drained();

    // Random phases with different idling and active counts
    for (int p = 0; p < 4; p++) begin
      write_active_count(7'(count_plan[p]));
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      repeat (ITEMS_PER_PHASE) send_random_request();
      in_valid_i <= 1'b0;
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (80) @(posedge clk_i);
    if (circle_table.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
